[hdl/versioned_revocation_set_unit_macros.svh]
// Assertion macros shared by the checker of the revocation set unit
`ifndef VERSIONED_REVOCATION_SET_UNIT_MACROS_SVH
`define VERSIONED_REVOCATION_SET_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define VRS_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled while reset is low
`define VRS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |=> (post)) else $error(msg);

`endif

[hdl/vrs_pkg.sv]
// Package of types and constants for the versioned revocation set unit
package vrs_pkg;

    // Default storage depth and register reset value
    localparam int ENTRY_DEPTH_DEF = 64;
    localparam int CFG_W           = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
    localparam int DIGEST_W        = 256;

    typedef enum logic [1:0] {
        KIND_BEGIN  = 2'd0,
        KIND_ENTRY  = 2'd1,
        KIND_REVOKE = 2'd2,
        KIND_CHECK  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        STAT_APPLIED = 3'd0,
        STAT_STALE   = 3'd1,
        STAT_GAP     = 3'd2,
        STAT_LIMIT   = 3'd3,
        STAT_ERROR   = 3'd4,
        STAT_CLEAR   = 3'd5,
        STAT_REVOKED = 3'd6,
        STAT_UNKNOWN = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_EVAL  = 3'd1,
        S_SCAN  = 3'd2,
        S_APPLY = 3'd3,
        S_OUT   = 3'd4
    } t_state;

endpackage

[hdl/versioned_revocation_set_unit.sv]
// Versioned revocation set: sequencer, digest memory and version state
//
// Requests enter on i_valid/o_stall and are taken when i_valid is high and
// o_stall low. One request is worked on at a time; o_stall is high from the
// cycle after acceptance until the work is finished. A request that gives a
// result places it in an output register (o_valid/i_stall); the next request
// is taken while that result still waits. Snapshot begins that open a
// session and non-final entries give no result.
// A digest search covers the held digests, or for an entry the entries
// staged so far, and ends early on a hit. The next request can be taken
// in the cycle after the result leaves the sequencer. The search reads one
// memory word per cycle from a single read port and compares it in the one
// comparator.
// The memory holds two banks; a snapshot commit swaps the active bank.
// If the receiver stalls, the finished result waits in the sequencer and no
// new request is taken until the output register frees.
// Reset (synchronous, active low) clears version state, counts and o_valid,
// and sets the entry limit to 64; memory is not cleared. The entry limit is
// for the user to write via i_cfg_we/i_cfg_wdata when idle; not enforced.
module versioned_revocation_set_unit #(
    parameter int ENTRY_DEPTH = vrs_pkg::ENTRY_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [vrs_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_kind,
    input  logic [63:0]                i_epoch,
    input  logic [63:0]                i_sequence_req,
    input  logic [15:0]                i_entry_count,
    input  logic [63:0]                i_digest_word0,
    input  logic [63:0]                i_digest_word1,
    input  logic [63:0]                i_digest_word2,
    input  logic [63:0]                i_digest_word3,
    input  logic                       i_digest_valid,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [2:0]                 o_status,
    output logic                       o_synchronized,
    output logic [63:0]                o_current_epoch,
    output logic [63:0]                o_current_sequence,
    output logic [6:0]                 o_stored_count
);

    localparam int CNT_W     = $clog2(ENTRY_DEPTH + 1);
    localparam int IDX_W     = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int ADDR_W    = IDX_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    function automatic logic ver_less(input logic [63:0] e, input logic [63:0] s,
                                      input logic [63:0] oe, input logic [63:0] os);
        return (e < oe) || ((e == oe) && (s < os));
    endfunction

    // Sequencer and request registers
    vrs_pkg::t_state  r_state, n_state;
    vrs_pkg::t_kind   r_kind;
    logic [63:0]      r_ep, r_sq;
    logic [15:0]      r_cnt;
    logic [vrs_pkg::DIGEST_W-1:0] r_dg;
    logic             r_dv;

    // Version and set state
    logic [vrs_pkg::CFG_W-1:0] r_max;
    logic [63:0]      r_set_ep, n_set_ep, r_set_sq, n_set_sq;
    logic [63:0]      r_need_ep, n_need_ep, r_need_sq, n_need_sq;
    logic [CNT_W-1:0] r_held, n_held;
    logic             r_sync, n_sync, r_bank, n_bank;
    logic             r_open, n_open;
    logic [63:0]      r_sess_ep, n_sess_ep, r_sess_sq, n_sess_sq;
    logic [CNT_W-1:0] r_sess_exp, n_sess_exp, r_sess_rcv, n_sess_rcv;

    // Search state
    logic [CNT_W-1:0] r_idx, n_idx, r_scan_n, n_scan_n;
    logic             r_scan_bank, n_scan_bank, r_pend, n_pend, r_found, n_found;

    // Result and output register
    vrs_pkg::t_status r_status, n_status;
    vrs_pkg::t_status r_o_status;
    logic             r_o_valid, r_o_sync;
    logic [63:0]      r_o_ep, r_o_sq;
    logic [6:0]       r_o_cnt;
    logic             o_load;

    // Digest memory, two banks
    logic [vrs_pkg::DIGEST_W-1:0] r_mem [MEM_DEPTH];
    logic [vrs_pkg::DIGEST_W-1:0] r_rd_data;
    logic             rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;

    logic [31:0]      lim32;
    logic [63:0]      seq_next;
    logic             rev_ok, hit, do_need, need_take, search;
    logic [63:0]      nd_ep, nd_sq;

    // Clamp the configured limit to 1..ENTRY_DEPTH
    always_comb begin
        lim32 = 32'(r_max);
        if (lim32 == 32'd0) begin
            lim32 = 32'd1;
        end
        if (lim32 > 32'(ENTRY_DEPTH)) begin
            lim32 = 32'(ENTRY_DEPTH);
        end
    end

    assign seq_next = r_set_sq + 64'd1;
    assign rev_ok   = (r_ep != 64'd0) && (r_sq != 64'd0) && r_sync
                    && ver_less(r_set_ep, r_set_sq, r_ep, r_sq)
                    && (r_ep == r_set_ep) && (r_sq == seq_next) && r_dv;
    assign rd_addr  = {r_scan_bank, r_idx[IDX_W-1:0]};
    assign hit      = r_pend && (r_rd_data == r_dg);
    assign need_take = (r_need_ep == 64'd0) || ver_less(r_need_ep, r_need_sq, nd_ep, nd_sq);

    // Next state and datapath control
    always_comb begin
        n_state    = r_state;
        n_set_ep   = r_set_ep;
        n_set_sq   = r_set_sq;
        n_need_ep  = r_need_ep;
        n_need_sq  = r_need_sq;
        n_held     = r_held;
        n_sync     = r_sync;
        n_bank     = r_bank;
        n_open     = r_open;
        n_sess_ep  = r_sess_ep;
        n_sess_sq  = r_sess_sq;
        n_sess_exp = r_sess_exp;
        n_sess_rcv = r_sess_rcv;
        n_idx      = r_idx;
        n_scan_n   = r_scan_n;
        n_scan_bank = r_scan_bank;
        n_pend     = 1'b0;
        n_found    = r_found;
        n_status   = r_status;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = {r_bank, r_held[IDX_W-1:0]};
        do_need    = 1'b0;
        nd_ep      = r_ep;
        nd_sq      = r_sq;
        search     = 1'b0;
        o_load     = 1'b0;

        unique case (r_state)
            vrs_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = vrs_pkg::S_EVAL;
                end
            end
            // Decide whether a digest search is needed, and over which bank
            vrs_pkg::S_EVAL: begin
                n_idx       = '0;
                n_found     = 1'b0;
                n_scan_bank = r_bank;
                n_scan_n    = r_held;
                case (r_kind)
                    vrs_pkg::KIND_ENTRY: begin
                        if (r_open && r_dv && (32'(r_sess_rcv) < 32'(ENTRY_DEPTH))) begin
                            search      = 1'b1;
                            n_scan_bank = ~r_bank;
                            n_scan_n    = r_sess_rcv;
                        end
                    end
                    vrs_pkg::KIND_REVOKE: search = rev_ok;
                    vrs_pkg::KIND_CHECK:  search = r_sync && r_dv;
                    default: ;
                endcase
                n_state = search ? vrs_pkg::S_SCAN : vrs_pkg::S_APPLY;
            end
            // Read one word a cycle, compare the word read the cycle before
            vrs_pkg::S_SCAN: begin
                rd_en  = r_idx < r_scan_n;
                n_pend = rd_en;
                if (rd_en) begin
                    n_idx = r_idx + 1'b1;
                end
                if (hit) begin
                    n_found = 1'b1;
                    n_state = vrs_pkg::S_APPLY;
                end else if (!rd_en && !r_pend) begin
                    n_state = vrs_pkg::S_APPLY;
                end
            end
            // Update version state and the set, choose the result
            vrs_pkg::S_APPLY: begin
                n_state = vrs_pkg::S_OUT;
                if (r_kind != vrs_pkg::KIND_ENTRY) begin
                    n_open = 1'b0;
                end
                case (r_kind)
                    vrs_pkg::KIND_BEGIN: begin
                        if (r_ep == 64'd0) begin
                            n_status = vrs_pkg::STAT_ERROR;
                        end else if (r_sync ? !ver_less(r_set_ep, r_set_sq, r_ep, r_sq)
                                            : ((r_need_ep != 64'd0) &&
                                               ver_less(r_ep, r_sq, r_need_ep, r_need_sq))) begin
                            n_status = vrs_pkg::STAT_STALE;
                        end else if (32'(r_cnt) > lim32) begin
                            do_need  = 1'b1;
                            n_status = vrs_pkg::STAT_LIMIT;
                        end else if (r_cnt == 16'd0) begin
                            n_set_ep  = r_ep;
                            n_set_sq  = r_sq;
                            n_need_ep = 64'd0;
                            n_need_sq = 64'd0;
                            n_held    = '0;
                            n_sync    = 1'b1;
                            n_status  = vrs_pkg::STAT_APPLIED;
                        end else begin
                            n_open     = 1'b1;
                            n_sess_ep  = r_ep;
                            n_sess_sq  = r_sq;
                            n_sess_exp = CNT_W'(r_cnt);
                            n_sess_rcv = '0;
                            n_state    = vrs_pkg::S_IDLE;
                        end
                    end
                    vrs_pkg::KIND_ENTRY: begin
                        nd_ep = r_sess_ep;
                        nd_sq = r_sess_sq;
                        if (!r_open) begin
                            n_status = vrs_pkg::STAT_ERROR;
                        end else if (!r_dv || (32'(r_sess_rcv) >= 32'(ENTRY_DEPTH))
                                     || r_found) begin
                            n_open   = 1'b0;
                            do_need  = 1'b1;
                            n_status = vrs_pkg::STAT_ERROR;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = {~r_bank, r_sess_rcv[IDX_W-1:0]};
                            n_sess_rcv = r_sess_rcv + 1'b1;
                            if (n_sess_rcv < r_sess_exp) begin
                                n_state = vrs_pkg::S_IDLE;
                            end else begin
                                // Commit: swap banks
                                n_open    = 1'b0;
                                n_bank    = ~r_bank;
                                n_set_ep  = r_sess_ep;
                                n_set_sq  = r_sess_sq;
                                n_need_ep = 64'd0;
                                n_need_sq = 64'd0;
                                n_held    = n_sess_rcv;
                                n_sync    = 1'b1;
                                n_status  = vrs_pkg::STAT_APPLIED;
                            end
                        end
                    end
                    vrs_pkg::KIND_REVOKE: begin
                        if ((r_ep == 64'd0) || (r_sq == 64'd0)) begin
                            n_status = vrs_pkg::STAT_ERROR;
                        end else if (!r_sync) begin
                            do_need  = 1'b1;
                            n_status = r_dv ? vrs_pkg::STAT_GAP : vrs_pkg::STAT_ERROR;
                        end else if (!ver_less(r_set_ep, r_set_sq, r_ep, r_sq)) begin
                            n_status = vrs_pkg::STAT_STALE;
                        end else if ((r_ep != r_set_ep) || (r_sq != seq_next)) begin
                            do_need  = 1'b1;
                            n_status = vrs_pkg::STAT_GAP;
                        end else if (!r_dv) begin
                            do_need  = 1'b1;
                            n_status = vrs_pkg::STAT_ERROR;
                        end else if (!r_found && (32'(r_held) >= lim32)) begin
                            do_need  = 1'b1;
                            n_status = vrs_pkg::STAT_LIMIT;
                        end else begin
                            if (!r_found) begin
                                wr_en  = 1'b1;
                                n_held = r_held + 1'b1;
                            end
                            n_set_sq = r_sq;
                            n_status = vrs_pkg::STAT_APPLIED;
                        end
                    end
                    default: begin
                        if (!r_sync || !r_dv) begin
                            n_status = vrs_pkg::STAT_UNKNOWN;
                        end else begin
                            n_status = r_found ? vrs_pkg::STAT_REVOKED : vrs_pkg::STAT_CLEAR;
                        end
                    end
                endcase
            end
            // Hand the result to the output register once it is free
            vrs_pkg::S_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    o_load  = 1'b1;
                    n_state = vrs_pkg::S_IDLE;
                end
            end
            default: n_state = vrs_pkg::S_IDLE;
        endcase

        // Record the required snapshot version and drop sync
        if (do_need) begin
            if (need_take) begin
                n_need_ep = nd_ep;
                n_need_sq = nd_sq;
            end
            n_sync = 1'b0;
        end
    end

    // Control and version registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vrs_pkg::S_IDLE;
            r_max       <= vrs_pkg::CFG_RESET;
            r_set_ep    <= '0;
            r_set_sq    <= '0;
            r_need_ep   <= '0;
            r_need_sq   <= '0;
            r_held      <= '0;
            r_sync      <= 1'b0;
            r_bank      <= 1'b0;
            r_open      <= 1'b0;
            r_sess_ep   <= '0;
            r_sess_sq   <= '0;
            r_sess_exp  <= '0;
            r_sess_rcv  <= '0;
            r_idx       <= '0;
            r_scan_n    <= '0;
            r_scan_bank <= 1'b0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_status    <= vrs_pkg::STAT_APPLIED;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            r_set_ep    <= n_set_ep;
            r_set_sq    <= n_set_sq;
            r_need_ep   <= n_need_ep;
            r_need_sq   <= n_need_sq;
            r_held      <= n_held;
            r_sync      <= n_sync;
            r_bank      <= n_bank;
            r_open      <= n_open;
            r_sess_ep   <= n_sess_ep;
            r_sess_sq   <= n_sess_sq;
            r_sess_exp  <= n_sess_exp;
            r_sess_rcv  <= n_sess_rcv;
            r_idx       <= n_idx;
            r_scan_n    <= n_scan_n;
            r_scan_bank <= n_scan_bank;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_status    <= n_status;
            if (o_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Capture the request payload on acceptance
    always_ff @(posedge i_clk) begin
        if (r_state == vrs_pkg::S_IDLE && i_valid) begin
            r_kind <= vrs_pkg::t_kind'(i_kind);
            r_ep   <= i_epoch;
            r_sq   <= i_sequence_req;
            r_cnt  <= i_entry_count;
            r_dg   <= {i_digest_word0, i_digest_word1, i_digest_word2, i_digest_word3};
            r_dv   <= i_digest_valid;
        end
    end

    // Load the output payload
    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_o_status <= r_status;
            r_o_sync   <= r_sync;
            r_o_ep     <= r_set_ep;
            r_o_sq     <= r_set_sq;
            r_o_cnt    <= 7'(r_held);
        end
    end

    // Digest memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_dg;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_stall            = r_state != vrs_pkg::S_IDLE;
    assign o_valid            = r_o_valid;
    assign o_status           = r_o_status;
    assign o_synchronized     = r_o_sync;
    assign o_current_epoch    = r_o_ep;
    assign o_current_sequence = r_o_sq;
    assign o_stored_count     = r_o_cnt;

endmodule

[hdl/vrs_checker.sv]
// Port checker for the versioned revocation set unit, with its bind
`include "versioned_revocation_set_unit_macros.svh"

module vrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic        o_synchronized
);

    // A held result keeps its status
    `VRS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_status), "result dropped while stalled")

    // One request at a time: stall follows every acceptance
    `VRS_ASSERT_NEXT(a_one_req, i_valid && !o_stall, o_stall, "request taken while busy")

    // Only a synchronised set answers revoked or clear
    `VRS_ASSERT_NOW(a_check_sync, o_valid && (o_status == vrs_pkg::STAT_REVOKED || o_status == vrs_pkg::STAT_CLEAR), o_synchronized, "check answered while unsynchronised")

    // Gap and limit always leave the set unsynchronised
    `VRS_ASSERT_NOW(a_gap_desync, o_valid && (o_status == vrs_pkg::STAT_GAP || o_status == vrs_pkg::STAT_LIMIT), !o_synchronized, "gap or limit left set synchronised")

endmodule

bind versioned_revocation_set_unit vrs_checker u_vrs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_synchronized (o_synchronized)
);
